// File: hdl/sbp_fr_pkg.sv
// Shared types, constants and the CRC-16 XMODEM byte update for the SBP frame receiver.
// No dependencies; used by sbp_fr_apb, sbp_fr_parser and sbp_frame_receiver.
package sbp_fr_pkg;

    // Frame counters: internal width, and the width shown on the result channel
    localparam int COUNT_WIDTH = 32;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [31:0]            count_out_t;

    // Configuration port
    localparam int ADDR_WIDTH = 3;
    localparam int DATA_WIDTH = 32;
    typedef logic [0:0] reg_index_t;
    localparam reg_index_t REG_PREAMBLE    = 1'b0;
    localparam reg_index_t REG_SENDER_LOCK = 1'b1;

    localparam logic [7:0]  PREAMBLE_RESET    = 8'h55;
    localparam logic        SENDER_LOCK_RESET = 1'b1;

    // CRC-16 XMODEM
    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    typedef struct packed {
        logic [7:0] preamble_value;
        logic       sender_lock_enable;
    } cfg_t;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_TYPE    = 3'd1,
        PH_SENDER  = 3'd2,
        PH_LENGTH  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CRC     = 3'd5
    } phase_t;

    typedef enum logic {
        KIND_DATA    = 1'b0,
        KIND_VERDICT = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK              = 2'd0,
        ST_CRC_FAIL        = 2'd1,
        ST_SENDER_MISMATCH = 2'd2
    } status_t;

    typedef struct packed {
        kind_t      result_kind;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic [15:0] msg_type;
        logic [15:0] sender_id;
        logic [7:0] payload_length;
        status_t    frame_status;
        count_out_t good_frames;
        count_out_t failed_frames;
    } result_t;

    // One byte of CRC-16 XMODEM, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: hdl/sbp_frame_receiver.sv
// Top level of the SBP frame receiver: input register, parser, result register, APB port.
// Depends on sbp_fr_pkg, sbp_fr_apb and sbp_fr_parser.

// The receiver takes one serial byte per request on the s_ channel and sustains one byte
// per clock cycle. A byte sits in the input register while the parser steps its phase
// machine and CRC-16 XMODEM (polynomial 0x1021, initial value 0) over it, and the result,
// if the byte causes one, passes from the input register into the result register, where
// m_valid rises. The rate is set by the parser's combinational phase and CRC update; the
// input register can still take a byte while a finished result waits on m_ready, and the
// input stage stalls only when both the result register and the input register are full
// and m_ready is low. Frames start at a byte
// equal to preamble_value (register 0, reset 0x55) and carry little-endian type and sender
// id, a length byte, the payload and a little-endian CRC. Each payload byte comes out as a
// data result with its index; each frame ends in one verdict: CRC ok, CRC fail, or sender
// mismatch. With sender_lock_enable (register 1, reset 1) set, a frame whose sender id
// differs from the one latched on the first good frame is dropped right after its id.
// The good and failed frame counts wrap. Write the registers only while the block is idle.
module sbp_frame_receiver (
    input  logic                              aclk,
    input  logic                              aresetn,
    // byte requests
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_rx_byte,
    // results
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_result_kind,
    output logic [7:0]                        m_data_byte,
    output logic [7:0]                        m_byte_index,
    output logic [15:0]                       m_msg_type,
    output logic [15:0]                       m_sender_id,
    output logic [7:0]                        m_payload_length,
    output logic [1:0]                        m_frame_status,
    output logic [31:0]                       m_good_frames,
    output logic [31:0]                       m_failed_frames,
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sbp_fr_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [sbp_fr_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [sbp_fr_pkg::DATA_WIDTH-1:0] prdata,
    output logic                              pready
);

    sbp_fr_pkg::cfg_t    cfg;
    sbp_fr_pkg::result_t res;
    sbp_fr_pkg::result_t result_reg;
    logic                res_valid;
    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                m_valid_reg;
    logic                advance;
    logic                fire;

    sbp_fr_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The result slot is free when empty or being drained this cycle
    assign advance = !m_valid_reg || m_ready;
    // Process the held byte whenever its result (if any) has somewhere to go
    assign fire    = in_valid_reg && advance;
    // Take a new request when the input register is empty or moves on this cycle
    assign s_ready = !in_valid_reg || advance;

    // Input register: hold the byte until the parser takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    sbp_fr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .fire      (fire),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register: load on advance, drop the valid flag for bytes without a result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= fire && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= res;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_result_kind    = result_reg.result_kind;
    assign m_data_byte      = result_reg.data_byte;
    assign m_byte_index     = result_reg.byte_index;
    assign m_msg_type       = result_reg.msg_type;
    assign m_sender_id      = result_reg.sender_id;
    assign m_payload_length = result_reg.payload_length;
    assign m_frame_status   = result_reg.frame_status;
    assign m_good_frames    = result_reg.good_frames;
    assign m_failed_frames  = result_reg.failed_frames;

`ifndef SYNTHESIS
    // An empty result slot never blocks the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg |-> s_ready)
        else $error("s_ready low while result register is empty");

    // A held byte that cannot move stays put
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input register lost or changed a stalled byte");

    // Payload data results never carry a failure status
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (result_reg.result_kind == sbp_fr_pkg::KIND_DATA)
            |-> (result_reg.frame_status == sbp_fr_pkg::ST_OK))
        else $error("payload byte result with nonzero status");
`endif

endmodule

// File: hdl/sbp_fr_apb.sv
// APB-style configuration registers of the SBP frame receiver (preamble, sender lock).
// Depends on sbp_fr_pkg.
module sbp_fr_apb (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sbp_fr_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [sbp_fr_pkg::DATA_WIDTH-1:0] pwdata,
    output logic [sbp_fr_pkg::DATA_WIDTH-1:0] prdata,
    output logic                              pready,
    output sbp_fr_pkg::cfg_t                  cfg
);

    sbp_fr_pkg::cfg_t       cfg_reg;
    sbp_fr_pkg::reg_index_t index;
    logic                   wr_en;

    assign pready = 1'b1;
    assign index  = paddr[2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.preamble_value     <= sbp_fr_pkg::PREAMBLE_RESET;
            cfg_reg.sender_lock_enable <= sbp_fr_pkg::SENDER_LOCK_RESET;
        end else if (wr_en) begin
            unique case (index)
                sbp_fr_pkg::REG_PREAMBLE:    cfg_reg.preamble_value     <= pwdata[7:0];
                sbp_fr_pkg::REG_SENDER_LOCK: cfg_reg.sender_lock_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (index)
            sbp_fr_pkg::REG_PREAMBLE:    prdata[7:0] = cfg_reg.preamble_value;
            sbp_fr_pkg::REG_SENDER_LOCK: prdata[0]   = cfg_reg.sender_lock_enable;
            default: prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// File: hdl/sbp_fr_parser.sv
// Frame parser of the SBP frame receiver: phase machine, CRC, header fields and counters.
// Takes one byte per fire and gives at most one result; depends on sbp_fr_pkg.
module sbp_fr_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sbp_fr_pkg::cfg_t      cfg,
    input  logic                  fire,
    input  logic [7:0]            rx_byte,
    output logic                  res_valid,
    output sbp_fr_pkg::result_t   res
);

    sbp_fr_pkg::phase_t phase_reg, phase_next;
    logic [7:0]          byte_count_reg, byte_count_next;
    logic [15:0]         running_crc_reg, running_crc_next;
    logic [15:0]         type_reg, type_next;
    logic [15:0]         sender_reg, sender_next;
    logic [7:0]          length_reg, length_next;
    logic [15:0]         received_crc_reg, received_crc_next;
    logic [15:0]         known_sender_reg, known_sender_next;
    logic                known_valid_reg, known_valid_next;
    sbp_fr_pkg::count_t  good_count_reg, good_count_next;
    sbp_fr_pkg::count_t  fail_count_reg, fail_count_next;

    logic [15:0]         crc_upd;
    logic [15:0]         sender_full;
    logic [15:0]         rx_crc_full;
    logic [7:0]          count_inc;
    logic                mismatch;
    logic                crc_ok;

    sbp_fr_pkg::kind_t   r_kind;
    logic [7:0]          r_data;
    logic [7:0]          r_index;
    logic [7:0]          r_length;
    sbp_fr_pkg::status_t r_status;

    assign crc_upd     = sbp_fr_pkg::crc16_byte(running_crc_reg, rx_byte);
    assign sender_full = {rx_byte, sender_reg[7:0]};
    assign rx_crc_full = {rx_byte, received_crc_reg[7:0]};
    assign count_inc   = byte_count_reg + 8'd1;
    assign mismatch    = known_valid_reg && cfg.sender_lock_enable
                         && (sender_full != known_sender_reg);
    assign crc_ok      = (rx_crc_full == running_crc_reg);

    // Next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            sbp_fr_pkg::PH_TYPE: begin
                if (byte_count_reg != 8'd0) phase_next = sbp_fr_pkg::PH_SENDER;
            end
            sbp_fr_pkg::PH_SENDER: begin
                if (byte_count_reg != 8'd0) begin
                    phase_next = mismatch ? sbp_fr_pkg::PH_HUNT : sbp_fr_pkg::PH_LENGTH;
                end
            end
            sbp_fr_pkg::PH_LENGTH: begin
                phase_next = (rx_byte == 8'd0) ? sbp_fr_pkg::PH_CRC : sbp_fr_pkg::PH_PAYLOAD;
            end
            sbp_fr_pkg::PH_PAYLOAD: begin
                if (count_inc == length_reg) phase_next = sbp_fr_pkg::PH_CRC;
            end
            sbp_fr_pkg::PH_CRC: begin
                if (byte_count_reg != 8'd0) phase_next = sbp_fr_pkg::PH_HUNT;
            end
            default: begin
                phase_next = (rx_byte == cfg.preamble_value) ? sbp_fr_pkg::PH_TYPE
                                                             : sbp_fr_pkg::PH_HUNT;
            end
        endcase
    end

    // Datapath and result
    always_comb begin
        byte_count_next   = byte_count_reg;
        running_crc_next  = running_crc_reg;
        type_next         = type_reg;
        sender_next       = sender_reg;
        length_next       = length_reg;
        received_crc_next = received_crc_reg;
        known_sender_next = known_sender_reg;
        known_valid_next  = known_valid_reg;
        good_count_next   = good_count_reg;
        fail_count_next   = fail_count_reg;
        res_valid         = 1'b0;
        r_kind            = sbp_fr_pkg::KIND_DATA;
        r_data            = 8'd0;
        r_index           = 8'd0;
        r_length          = 8'd0;
        r_status          = sbp_fr_pkg::ST_OK;

        unique case (phase_reg)
            sbp_fr_pkg::PH_TYPE: begin
                running_crc_next = crc_upd;
                if (byte_count_reg == 8'd0) begin
                    type_next       = {8'd0, rx_byte};
                    byte_count_next = 8'd1;
                end else begin
                    type_next       = {rx_byte, type_reg[7:0]};
                    byte_count_next = 8'd0;
                end
            end
            sbp_fr_pkg::PH_SENDER: begin
                running_crc_next = crc_upd;
                if (byte_count_reg == 8'd0) begin
                    sender_next     = {8'd0, rx_byte};
                    byte_count_next = 8'd1;
                end else begin
                    sender_next     = sender_full;
                    byte_count_next = 8'd0;
                    if (mismatch) begin
                        res_valid = 1'b1;
                        r_kind    = sbp_fr_pkg::KIND_VERDICT;
                        r_status  = sbp_fr_pkg::ST_SENDER_MISMATCH;
                    end
                end
            end
            sbp_fr_pkg::PH_LENGTH: begin
                running_crc_next = crc_upd;
                length_next      = rx_byte;
                byte_count_next  = 8'd0;
            end
            sbp_fr_pkg::PH_PAYLOAD: begin
                running_crc_next = crc_upd;
                byte_count_next  = (count_inc == length_reg) ? 8'd0 : count_inc;
                res_valid        = 1'b1;
                r_data           = rx_byte;
                r_index          = byte_count_reg;
                r_length         = length_reg;
            end
            sbp_fr_pkg::PH_CRC: begin
                if (byte_count_reg == 8'd0) begin
                    received_crc_next = {8'd0, rx_byte};
                    byte_count_next   = 8'd1;
                end else begin
                    received_crc_next = rx_crc_full;
                    byte_count_next   = 8'd0;
                    res_valid         = 1'b1;
                    r_kind            = sbp_fr_pkg::KIND_VERDICT;
                    r_length          = length_reg;
                    if (crc_ok) begin
                        good_count_next = good_count_reg + sbp_fr_pkg::count_t'(1);
                        if (!known_valid_reg) begin
                            known_sender_next = sender_reg;
                            known_valid_next  = 1'b1;
                        end
                    end else begin
                        fail_count_next = fail_count_reg + sbp_fr_pkg::count_t'(1);
                        r_status        = sbp_fr_pkg::ST_CRC_FAIL;
                    end
                end
            end
            default: begin
                if (rx_byte == cfg.preamble_value) begin
                    byte_count_next   = 8'd0;
                    running_crc_next  = sbp_fr_pkg::CRC_INIT;
                    type_next         = 16'd0;
                    sender_next       = 16'd0;
                    length_next       = 8'd0;
                    received_crc_next = 16'd0;
                end
            end
        endcase

        res.result_kind    = r_kind;
        res.data_byte      = r_data;
        res.byte_index     = r_index;
        res.msg_type       = type_next;
        res.sender_id      = sender_next;
        res.payload_length = r_length;
        res.frame_status   = r_status;
        res.good_frames    = sbp_fr_pkg::count_out_t'(good_count_next);
        res.failed_frames  = sbp_fr_pkg::count_out_t'(fail_count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= sbp_fr_pkg::PH_HUNT;
            byte_count_reg   <= 8'd0;
            running_crc_reg  <= sbp_fr_pkg::CRC_INIT;
            type_reg         <= 16'd0;
            sender_reg       <= 16'd0;
            length_reg       <= 8'd0;
            received_crc_reg <= 16'd0;
            known_sender_reg <= 16'd0;
            known_valid_reg  <= 1'b0;
            good_count_reg   <= '0;
            fail_count_reg   <= '0;
        end else if (fire) begin
            phase_reg        <= phase_next;
            byte_count_reg   <= byte_count_next;
            running_crc_reg  <= running_crc_next;
            type_reg         <= type_next;
            sender_reg       <= sender_next;
            length_reg       <= length_next;
            received_crc_reg <= received_crc_next;
            known_sender_reg <= known_sender_next;
            known_valid_reg  <= known_valid_next;
            good_count_reg   <= good_count_next;
            fail_count_reg   <= fail_count_next;
        end
    end

endmodule

// File: verif/tb.sv
// Self-checking testbench for sbp_frame_receiver: byte requests in, payload and verdict results out.
// Depends on sbp_fr_pkg and the sbp_frame_receiver RTL; a frame tracker class predicts every result.
`timescale 1ns / 100ps

module tb;
    import sbp_fr_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    typedef logic [7:0] byte_q_t[$];

    typedef enum logic [1:0] {
        RX_FREE   = 2'd0,
        RX_COIN   = 2'd1,
        RX_SPARSE = 2'd2,
        RX_BUSY   = 2'd3
    } rx_mode_t;

    // CRC-16 XMODEM, one message bit at a time, MSB first
    function automatic logic [15:0] xmodem_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c;
        for (int k = 7; k >= 0; k--) begin
            r = (r[15] ^ b[k]) ? ({r[14:0], 1'b0} ^ CRC_POLY) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    // Tracks the receiver's frame state and holds the results still owed by the block
    class frame_tracker;
        cfg_t        cfg;
        phase_t      phase;
        logic [7:0]  count;
        logic [15:0] crc;
        logic [15:0] msg_type;
        logic [15:0] sender;
        logic [7:0]  length;
        logic [15:0] rx_crc;
        logic [15:0] known_sender;
        logic        known_valid;
        count_t      good_cnt;
        count_t      fail_cnt;
        result_t     due_results[$];
        int          mismatches;

        function new();
            cfg.preamble_value     = PREAMBLE_RESET;
            cfg.sender_lock_enable = SENDER_LOCK_RESET;
            phase        = PH_HUNT;
            count        = '0;
            crc          = CRC_INIT;
            msg_type     = '0;
            sender       = '0;
            length       = '0;
            rx_crc       = '0;
            known_sender = '0;
            known_valid  = 1'b0;
            good_cnt     = '0;
            fail_cnt     = '0;
            mismatches   = 0;
        endfunction

        function void set_reg(input reg_index_t idx, input logic [31:0] value);
            if (idx == REG_PREAMBLE) begin
                cfg.preamble_value = value[7:0];
            end else begin
                cfg.sender_lock_enable = value[0];
            end
        endfunction

        // Step the frame state by one accepted byte and queue the result it causes
        function void take_byte(input logic [7:0] b);
            result_t r;
            logic    emit_it;
            r       = '0;
            emit_it = 1'b0;
            case (phase)
                PH_TYPE: begin
                    crc = xmodem_next(crc, b);
                    if (count == 0) begin
                        msg_type = {8'h00, b};
                        count    = 8'd1;
                    end else begin
                        msg_type[15:8] = b;
                        count          = '0;
                        phase          = PH_SENDER;
                    end
                end
                PH_SENDER: begin
                    crc = xmodem_next(crc, b);
                    if (count == 0) begin
                        sender = {8'h00, b};
                        count  = 8'd1;
                    end else begin
                        sender[15:8] = b;
                        count        = '0;
                        phase        = PH_LENGTH;
                        if (known_valid && cfg.sender_lock_enable && sender != known_sender) begin
                            phase          = PH_HUNT;
                            r.result_kind  = KIND_VERDICT;
                            r.frame_status = ST_SENDER_MISMATCH;
                            emit_it        = 1'b1;
                        end
                    end
                end
                PH_LENGTH: begin
                    crc    = xmodem_next(crc, b);
                    length = b;
                    count  = '0;
                    phase  = (b == 0) ? PH_CRC : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    crc              = xmodem_next(crc, b);
                    r.result_kind    = KIND_DATA;
                    r.data_byte      = b;
                    r.byte_index     = count;
                    r.payload_length = length;
                    r.frame_status   = ST_OK;
                    emit_it          = 1'b1;
                    count            = count + 8'd1;
                    if (count == length) begin
                        count = '0;
                        phase = PH_CRC;
                    end
                end
                PH_CRC: begin
                    if (count == 0) begin
                        rx_crc = {8'h00, b};
                        count  = 8'd1;
                    end else begin
                        rx_crc[15:8]     = b;
                        count            = '0;
                        phase            = PH_HUNT;
                        r.result_kind    = KIND_VERDICT;
                        r.payload_length = length;
                        emit_it          = 1'b1;
                        if (rx_crc == crc) begin
                            good_cnt       = good_cnt + 1'b1;
                            r.frame_status = ST_OK;
                            if (!known_valid) begin
                                known_sender = sender;
                                known_valid  = 1'b1;
                            end
                        end else begin
                            fail_cnt       = fail_cnt + 1'b1;
                            r.frame_status = ST_CRC_FAIL;
                        end
                    end
                end
                default: begin
                    phase = PH_HUNT;
                    if (b == cfg.preamble_value) begin
                        phase    = PH_TYPE;
                        count    = '0;
                        crc      = CRC_INIT;
                        msg_type = '0;
                        sender   = '0;
                        length   = '0;
                        rx_crc   = '0;
                    end
                end
            endcase
            if (emit_it) begin
                r.msg_type      = msg_type;
                r.sender_id     = sender;
                r.good_frames   = count_out_t'(good_cnt);
                r.failed_frames = count_out_t'(fail_cnt);
                due_results.push_back(r);
            end
        endfunction

        function void flag(input string what, input logic [31:0] want, input logic [31:0] got);
            mismatches++;
            if (mismatches <= 10) begin
                $display("ERROR %t: %s expected 0x%0h, got 0x%0h", $realtime, what, want, got);
            end
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (due_results.size() == 0) begin
                flag("result with no request pending, kind", 32'hFFFF_FFFF, got.result_kind);
                return;
            end
            want = due_results.pop_front();
            if (got.result_kind != want.result_kind)
                flag("result_kind", want.result_kind, got.result_kind);
            if (got.data_byte != want.data_byte)
                flag("data_byte", want.data_byte, got.data_byte);
            if (got.byte_index != want.byte_index)
                flag("byte_index", want.byte_index, got.byte_index);
            if (got.msg_type != want.msg_type)
                flag("msg_type", want.msg_type, got.msg_type);
            if (got.sender_id != want.sender_id)
                flag("sender_id", want.sender_id, got.sender_id);
            if (got.payload_length != want.payload_length)
                flag("payload_length", want.payload_length, got.payload_length);
            if (got.frame_status != want.frame_status)
                flag("frame_status", want.frame_status, got.frame_status);
            if (got.good_frames != want.good_frames)
                flag("good_frames", want.good_frames, got.good_frames);
            if (got.failed_frames != want.failed_frames)
                flag("failed_frames", want.failed_frames, got.failed_frames);
        endfunction
    endclass

    // Every input starts at a known value
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_rx_byte = 8'h00;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_result_kind;
    logic [7:0]            m_data_byte;
    logic [7:0]            m_byte_index;
    logic [15:0]           m_msg_type;
    logic [15:0]           m_sender_id;
    logic [7:0]            m_payload_length;
    logic [1:0]            m_frame_status;
    logic [31:0]           m_good_frames;
    logic [31:0]           m_failed_frames;
    logic                  psel      = 1'b0;
    logic                  penable   = 1'b0;
    logic                  pwrite    = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr     = '0;
    logic [DATA_WIDTH-1:0] pwdata    = '0;
    logic [DATA_WIDTH-1:0] prdata;
    logic                  pready;

    frame_tracker book = new();
    result_t      seen;
    int           cycles     = 0;
    int           bytes_sent = 0;
    int           burst_left = 0;
    rx_mode_t     rx_mode    = RX_FREE;
    int           rx_left    = 0;

    sbp_frame_receiver uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_data_byte      (m_data_byte),
        .m_byte_index     (m_byte_index),
        .m_msg_type       (m_msg_type),
        .m_sender_id      (m_sender_id),
        .m_payload_length (m_payload_length),
        .m_frame_status   (m_frame_status),
        .m_good_frames    (m_good_frames),
        .m_failed_frames  (m_failed_frames),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Gather the result ports into one struct for the checker
    always_comb begin
        seen.result_kind    = kind_t'(m_result_kind);
        seen.data_byte      = m_data_byte;
        seen.byte_index     = m_byte_index;
        seen.msg_type       = m_msg_type;
        seen.sender_id      = m_sender_id;
        seen.payload_length = m_payload_length;
        seen.frame_status   = status_t'(m_frame_status);
        seen.good_frames    = m_good_frames;
        seen.failed_frames  = m_failed_frames;
    end

    // Sample both handshakes at the edge; predict on each accepted request, check each result
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                book.take_byte(s_rx_byte);
            end
            if (m_valid && m_ready) begin
                book.check_result(seen);
            end
        end
    end

    // Receiver back-pressure: each time rx_left runs down, switch between free flow, coin flips,
    // one-in-four acceptance and mostly-ready, so stalls land on every frame phase
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_left <= 63;
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_FREE:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= (rx_left % 4 == 0);
            default:   m_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Cycle counter and watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
    end

    initial begin
        wait (cycles >= CYCLE_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    // Offer one byte request; open a new burst after a random gap when the old one runs out.
    // Hold valid and the byte until the edge that accepts them.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // Build preamble, header, payload and CRC; corrupt the CRC or drop the tail on request
    task automatic send_frame(input logic [15:0] typ, input logic [15:0] sid,
                              input byte_q_t body, input bit crc_ok, input int cut);
        byte_q_t     frame;
        logic [15:0] c;
        frame = {book.cfg.preamble_value, typ[7:0], typ[15:8], sid[7:0], sid[15:8],
                 8'(body.size())};
        foreach (body[i]) frame.push_back(body[i]);
        c = CRC_INIT;
        for (int i = 1; i < frame.size(); i++) c = xmodem_next(c, frame[i]);
        if (!crc_ok) c ^= 16'($urandom_range(1, 65535));
        frame.push_back(c[7:0]);
        frame.push_back(c[15:8]);
        if (cut > 0) begin
            while (frame.size() > cut) void'(frame.pop_back());
        end
        foreach (frame[i]) send_byte(frame[i]);
    endtask

    // Mostly well-formed frames with random content, some aimed at the latched sender,
    // plus line noise and frames cut short
    task automatic run_traffic(input int quota);
        int          stop_at;
        int          pick;
        int          len;
        int          cut;
        logic [15:0] sid;
        byte_q_t     body;
        stop_at = bytes_sent + quota;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
                sid = (book.known_valid && $urandom_range(0, 5) != 0) ? book.known_sender
                                                                       : 16'($urandom);
                len = $urandom_range(0, 99);
                if (len < 2)       len = $urandom_range(128, 255);
                else if (len < 12) len = 0;
                else               len = $urandom_range(1, 16);
                body.delete();
                repeat (len) body.push_back(8'($urandom));
                cut = 0;
                if (pick < 16) begin
                    cut = $urandom_range(1, len + 7);
                end else if (book.known_valid && book.cfg.sender_lock_enable &&
                             sid != book.known_sender && $urandom_range(0, 1) == 1) begin
                    cut = 5;
                end
                send_frame(16'($urandom), sid, body, $urandom_range(0, 7) != 0, cut);
            end
        end
    endtask

    // Stop sending, wait for every owed result, then let the pipeline settle
    task automatic wait_drained();
        s_valid    <= 1'b0;
        burst_left = 0;
        while (book.due_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Setup phase, then access phase; the register takes the value at the edge with pready high
    task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        book.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        byte_q_t body;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames at reset settings: noise at both byte extremes, a good empty
        // frame that latches sender 0xFFFF, a bad-CRC frame carrying the preamble value
        // in its payload, and a frame from another sender dropped after its id
        send_byte(8'h00);
        send_byte(8'hFF);
        body = {};
        send_frame(16'h0000, 16'hFFFF, body, 1'b1, 0);
        body = {8'h55, 8'hFF};
        send_frame(16'hFFFF, 16'hFFFF, body, 1'b0, 0);
        send_frame(16'h1234, 16'h0000, body, 1'b1, 5);
        run_traffic(500);

        // Preamble at the low extreme, sender lock off
        wait_drained();
        write_reg(REG_PREAMBLE, {24'($urandom), 8'h00});
        write_reg(REG_SENDER_LOCK, {31'($urandom), 1'b0});
        run_traffic(500);

        // Preamble at the high extreme, lock back on; one full-length payload first
        wait_drained();
        write_reg(REG_PREAMBLE, {24'($urandom), 8'hFF});
        write_reg(REG_SENDER_LOCK, {31'($urandom), 1'b1});
        body.delete();
        repeat (255) body.push_back(8'($urandom));
        send_frame(16'($urandom), book.known_sender, body, 1'b1, 0);
        run_traffic(500);

        // Random preamble and lock setting
        wait_drained();
        write_reg(REG_PREAMBLE, $urandom);
        write_reg(REG_SENDER_LOCK, $urandom);
        run_traffic(500);

        wait_drained();
        if (book.mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/sbp_fr_pkg.sv
hdl/sbp_fr_apb.sv
hdl/sbp_fr_parser.sv
hdl/sbp_frame_receiver.sv
verif/tb.sv
